@@ hw/rtl/rmq_pkg.sv @@
// Shared widths, codes and stage payload types of the matrix-to-quaternion pipeline.
`timescale 1ns / 1ps
package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int MW        = 16;                        // matrix entry and result width
  localparam int TW        = MW + 2;                    // trace width
  localparam int AW        = MW + 4;                    // square-root argument width (signed)
  localparam int NUMW      = MW + 1;                    // numerator width (signed)
  localparam int XW        = 2 * ((AW - 1 + FRAC_BITS + 2 + 1) / 2); // radicand width
  localparam int SW        = XW / 2;                    // square root width
  localparam int NW        = NUMW + FRAC_BITS + 1;      // dividend width
  localparam int QW        = NW - FRAC_BITS / 2 - 1;    // quotient width
  localparam int DVW       = SW + QW;                   // shifted divisor width
  localparam int SQ_STAGES = XW / 2;
  localparam int DV_STAGES = QW;

  localparam logic [QW-1:0] QPOS_MAX = QW'((1 << (MW - 1)) - 1);
  localparam logic [QW-1:0] QNEG_MAX = QW'(1 << (MW - 1));

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  typedef struct packed {
    logic signed [MW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } mat_t;

  typedef struct packed {
    logic                   bad;
    logic                   trace_br;
    axis_t                  imax;
    logic signed [NUMW-1:0] n0, n1, n2;
  } side_t;

  typedef struct packed {
    logic [XW-1:0] x;
    side_t         side;
  } sqin_t;

  typedef struct packed {
    logic [SW-1:0] s;
    side_t         side;
  } sqout_t;

  typedef struct packed {
    logic [2:0][QW-1:0] q;
    logic [SW-1:0]      s;
    side_t              side;
  } dvout_t;

  typedef struct packed {
    logic signed [MW-1:0] q_scalar, q_x, q_y, q_z;
    logic                 not_rotation;
  } res_t;

endpackage

@@ hw/rtl/rmq_in_if.sv @@
// Request channel carrying one rotation matrix.
`timescale 1ns / 1ps
interface rmq_in_if import rmq_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [MW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

@@ hw/rtl/rmq_out_if.sv @@
// Result channel carrying one quaternion and the not-a-rotation flag.
`timescale 1ns / 1ps
interface rmq_out_if import rmq_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [MW-1:0] q_scalar, q_x, q_y, q_z;
  logic not_rotation;

  modport source (output valid, q_scalar, q_x, q_y, q_z, not_rotation, input ready);
  modport sink   (input valid, q_scalar, q_x, q_y, q_z, not_rotation, output ready);
endinterface

@@ hw/rtl/rmq_front.sv @@
// Front stages: trace, largest diagonal, branch choice, radicand and numerators.
`timescale 1ns / 1ps
module rmq_front import rmq_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   up_valid,
  output logic   up_ready,
  input  mat_t   up_data,
  output logic   dn_valid,
  input  logic   dn_ready,
  output sqin_t  dn_data
);

  typedef struct packed {
    mat_t                 m;
    logic signed [TW-1:0] t;
    axis_t                imax;
    logic signed [MW-1:0] dmax;
  } f1_t;

  logic [1:0] v_r;
  logic [1:0] en;
  f1_t        f1_r, f1_nxt;
  sqin_t      f2_r, f2_nxt;

  assign en[1]    = !v_r[1] || dn_ready;
  assign en[0]    = !v_r[0] || en[1];
  assign up_ready = en[0];
  assign dn_valid = v_r[1];
  assign dn_data  = f2_r;

  // trace and largest diagonal, lowest index wins ties
  always_comb begin
    f1_nxt.m    = up_data;
    f1_nxt.t    = TW'(up_data.m00) + TW'(up_data.m11) + TW'(up_data.m22);
    f1_nxt.imax = AX_X;
    f1_nxt.dmax = up_data.m00;
    if (up_data.m11 > up_data.m00) begin
      f1_nxt.imax = AX_Y;
      f1_nxt.dmax = up_data.m11;
    end
    if (up_data.m22 > f1_nxt.dmax) begin
      f1_nxt.imax = AX_Z;
      f1_nxt.dmax = up_data.m22;
    end
  end

  // branch, argument and the three numerators
  always_comb begin
    logic signed [AW-1:0] a;
    logic signed [AW-1:0] one;
    logic                 tb;
    one = AW'(1) <<< FRAC_BITS;
    tb  = TW'(f1_r.dmax) < f1_r.t;
    a   = tb ? (one + AW'(f1_r.t))
             : ((AW'(f1_r.dmax) <<< 1) + one - AW'(f1_r.t));
    f2_nxt.side.bad      = (a <= 0);
    f2_nxt.side.trace_br = tb;
    f2_nxt.side.imax     = f1_r.imax;
    f2_nxt.x             = XW'(unsigned'(a[AW-2:0])) << (FRAC_BITS + 2);
    if (tb) begin
      f2_nxt.side.n0 = NUMW'(f1_r.m.m21) - NUMW'(f1_r.m.m12);
      f2_nxt.side.n1 = NUMW'(f1_r.m.m02) - NUMW'(f1_r.m.m20);
      f2_nxt.side.n2 = NUMW'(f1_r.m.m10) - NUMW'(f1_r.m.m01);
    end else begin
      unique case (f1_r.imax)
        AX_Y: begin
          f2_nxt.side.n0 = NUMW'(f1_r.m.m02) - NUMW'(f1_r.m.m20);
          f2_nxt.side.n1 = NUMW'(f1_r.m.m21) + NUMW'(f1_r.m.m12);
          f2_nxt.side.n2 = NUMW'(f1_r.m.m01) + NUMW'(f1_r.m.m10);
        end
        AX_Z: begin
          f2_nxt.side.n0 = NUMW'(f1_r.m.m10) - NUMW'(f1_r.m.m01);
          f2_nxt.side.n1 = NUMW'(f1_r.m.m02) + NUMW'(f1_r.m.m20);
          f2_nxt.side.n2 = NUMW'(f1_r.m.m12) + NUMW'(f1_r.m.m21);
        end
        default: begin
          f2_nxt.side.n0 = NUMW'(f1_r.m.m21) - NUMW'(f1_r.m.m12);
          f2_nxt.side.n1 = NUMW'(f1_r.m.m10) + NUMW'(f1_r.m.m01);
          f2_nxt.side.n2 = NUMW'(f1_r.m.m20) + NUMW'(f1_r.m.m02);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      if (en[1]) v_r[1] <= v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) f1_r <= f1_nxt;
    if (en[1]) f2_r <= f2_nxt;
  end

endmodule

@@ hw/rtl/rmq_sqrt.sv @@
// Pipelined restoring integer square root, one result bit per stage.
`timescale 1ns / 1ps
module rmq_sqrt import rmq_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   up_valid,
  output logic   up_ready,
  input  sqin_t  up_data,
  output logic   dn_valid,
  input  logic   dn_ready,
  output sqout_t dn_data
);

  typedef struct packed {
    logic [XW-1:0] x;
    logic [XW-1:0] r;
    side_t         side;
  } sq_t;

  logic [SQ_STAGES-1:0] v_r;
  logic [SQ_STAGES-1:0] en;
  sq_t                  st_r   [SQ_STAGES];
  sq_t                  st_nxt [SQ_STAGES];
  sq_t                  st_in  [SQ_STAGES];

  function automatic sq_t sq_step(input sq_t a, input int i);
    sq_t           o;
    logic [XW-1:0] b;
    logic [XW-1:0] t;
    o = a;
    b = XW'(1) << (XW - 2 - 2 * i);
    t = a.r + b;
    if (a.x >= t) begin
      o.x = a.x - t;
      o.r = (a.r >> 1) + b;
    end else begin
      o.r = a.r >> 1;
    end
    return o;
  endfunction

  always_comb begin
    en[SQ_STAGES-1] = !v_r[SQ_STAGES-1] || dn_ready;
    for (int i = SQ_STAGES - 2; i >= 0; i--) en[i] = !v_r[i] || en[i+1];
  end

  assign up_ready     = en[0];
  assign dn_valid     = v_r[SQ_STAGES-1];
  assign dn_data.s    = st_r[SQ_STAGES-1].r[SW-1:0];
  assign dn_data.side = st_r[SQ_STAGES-1].side;

  always_comb begin
    st_in[0].x    = up_data.x;
    st_in[0].r    = '0;
    st_in[0].side = up_data.side;
    for (int i = 1; i < SQ_STAGES; i++) st_in[i] = st_r[i-1];
    for (int i = 0; i < SQ_STAGES; i++) st_nxt[i] = sq_step(st_in[i], i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int i = 1; i < SQ_STAGES; i++) if (en[i]) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SQ_STAGES; i++) if (en[i]) st_r[i] <= st_nxt[i];
  end

endmodule

@@ hw/rtl/rmq_div.sv @@
// Three-lane pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module rmq_div import rmq_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   up_valid,
  output logic   up_ready,
  input  sqout_t up_data,
  output logic   dn_valid,
  input  logic   dn_ready,
  output dvout_t dn_data
);

  typedef struct packed {
    logic [2:0][NW-1:0] rem;
    logic [2:0][QW-1:0] q;
    logic [SW-1:0]      s;
    side_t              side;
  } dv_t;

  logic [DV_STAGES-1:0] v_r;
  logic [DV_STAGES-1:0] en;
  dv_t                  st_r   [DV_STAGES];
  dv_t                  st_nxt [DV_STAGES];
  dv_t                  st_in  [DV_STAGES];

  function automatic logic [NW-1:0] dividend(input logic signed [NUMW-1:0] n,
                                             input logic [SW-1:0] s);
    logic [NUMW-1:0] mag;
    mag = (n < 0) ? NUMW'(-n) : NUMW'(n);
    return (NW'(mag) << FRAC_BITS) + NW'(s >> 1);
  endfunction

  function automatic dv_t dv_step(input dv_t a, input int i);
    dv_t            o;
    logic [DVW-1:0] d;
    logic [DVW-1:0] rw;
    int             b;
    o = a;
    b = QW - 1 - i;
    d = DVW'(a.s) << b;
    for (int l = 0; l < 3; l++) begin
      rw = DVW'(a.rem[l]);
      if (rw >= d) begin
        o.rem[l]  = NW'(rw - d);
        o.q[l][b] = 1'b1;
      end
    end
    return o;
  endfunction

  always_comb begin
    en[DV_STAGES-1] = !v_r[DV_STAGES-1] || dn_ready;
    for (int i = DV_STAGES - 2; i >= 0; i--) en[i] = !v_r[i] || en[i+1];
  end

  assign up_ready     = en[0];
  assign dn_valid     = v_r[DV_STAGES-1];
  assign dn_data.q    = st_r[DV_STAGES-1].q;
  assign dn_data.s    = st_r[DV_STAGES-1].s;
  assign dn_data.side = st_r[DV_STAGES-1].side;

  always_comb begin
    st_in[0].rem[0] = dividend(up_data.side.n0, up_data.s);
    st_in[0].rem[1] = dividend(up_data.side.n1, up_data.s);
    st_in[0].rem[2] = dividend(up_data.side.n2, up_data.s);
    st_in[0].q      = '0;
    st_in[0].s      = up_data.s;
    st_in[0].side   = up_data.side;
    for (int i = 1; i < DV_STAGES; i++) st_in[i] = st_r[i-1];
    for (int i = 0; i < DV_STAGES; i++) st_nxt[i] = dv_step(st_in[i], i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int i = 1; i < DV_STAGES; i++) if (en[i]) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DV_STAGES; i++) if (en[i]) st_r[i] <= st_nxt[i];
  end

endmodule

@@ hw/rtl/rmq_out.sv @@
// Output stage: root rounding, sign and saturation, component placement.
`timescale 1ns / 1ps
module rmq_out import rmq_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   up_valid,
  output logic   up_ready,
  input  dvout_t up_data,
  output logic   dn_valid,
  input  logic   dn_ready,
  output res_t   dn_data
);

  logic v_r;
  res_t res_r, res_nxt;

  function automatic logic signed [MW-1:0] sat_lane(input logic [QW-1:0] q, input logic neg);
    logic signed [MW-1:0] v;
    if (!neg) v = (q > QPOS_MAX) ? MW'(QPOS_MAX) : MW'(q);
    else      v = (q >= QNEG_MAX) ? MW'(QNEG_MAX) : MW'(MW'(0) - q[MW-1:0]);
    return v;
  endfunction

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = res_r;

  always_comb begin
    logic [SW:0]          rt;
    logic signed [MW-1:0] root, d0, d1, d2;
    rt   = (SW+1)'(up_data.s) + (SW+1)'(2);
    rt   = rt >> 2;
    root = (rt > (SW+1)'(QPOS_MAX)) ? MW'(QPOS_MAX) : MW'(rt);
    d0   = sat_lane(up_data.q[0], up_data.side.n0[NUMW-1]);
    d1   = sat_lane(up_data.q[1], up_data.side.n1[NUMW-1]);
    d2   = sat_lane(up_data.q[2], up_data.side.n2[NUMW-1]);
    res_nxt.not_rotation = up_data.side.bad;
    if (up_data.side.bad) begin
      res_nxt.q_scalar = '0;
      res_nxt.q_x      = '0;
      res_nxt.q_y      = '0;
      res_nxt.q_z      = '0;
    end else if (up_data.side.trace_br) begin
      res_nxt.q_scalar = root;
      res_nxt.q_x      = d0;
      res_nxt.q_y      = d1;
      res_nxt.q_z      = d2;
    end else begin
      res_nxt.q_scalar = d0;
      unique case (up_data.side.imax)
        AX_Y: begin
          res_nxt.q_x = d2;
          res_nxt.q_y = root;
          res_nxt.q_z = d1;
        end
        AX_Z: begin
          res_nxt.q_x = d1;
          res_nxt.q_y = d2;
          res_nxt.q_z = root;
        end
        default: begin
          res_nxt.q_x = root;
          res_nxt.q_y = d1;
          res_nxt.q_z = d2;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) res_r <= res_nxt;
  end

endmodule

@@ hw/rtl/rotation_matrix_to_quaternion.sv @@
// Top level: rotation matrix to unit quaternion, Spurrier's method, fully pipelined.
`timescale 1ns / 1ps
// Converts one 3x3 rotation matrix per request (Q2.14 entries, 16384 = 1.0) into the
// scalar-first unit quaternion in the same format. The trace is compared with the largest
// diagonal entry (ties go to the lower index, a tie with the trace goes to the diagonal),
// the chosen component comes from a square root of four times the argument and is rounded
// half up, and the other three are quotients rounded to nearest with ties away from zero.
// Every component saturates to the 16-bit range. A non-positive square-root argument gives
// an all-zero quaternion with not_rotation set. Throughput is one request per clock while
// results are taken, through two front stages, 18 square-root stages (one root bit each),
// 24 divider stages (one quotient bit each, three lanes side by side) and the output
// register. Each stage advances when its successor has room, so bubbles close up and
// a stalled result holds only as many stages as are full. No state carries between requests.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rmq_in_if.sink    in_ch,
  rmq_out_if.source out_ch
);

  mat_t   in_mat;
  logic   fr_valid, fr_ready;
  sqin_t  fr_data;
  logic   sq_valid, sq_ready;
  sqout_t sq_data;
  logic   dv_valid, dv_ready;
  dvout_t dv_data;
  res_t   res;

  // gather request fields
  assign in_mat.m00 = in_ch.m00;
  assign in_mat.m01 = in_ch.m01;
  assign in_mat.m02 = in_ch.m02;
  assign in_mat.m10 = in_ch.m10;
  assign in_mat.m11 = in_ch.m11;
  assign in_mat.m12 = in_ch.m12;
  assign in_mat.m20 = in_ch.m20;
  assign in_mat.m21 = in_ch.m21;
  assign in_mat.m22 = in_ch.m22;

  // trace, branch selection, radicand and numerators
  rmq_front u_front (
    .clk, .rst_n,
    .up_valid (in_ch.valid), .up_ready (in_ch.ready), .up_data (in_mat),
    .dn_valid (fr_valid),    .dn_ready (fr_ready),    .dn_data (fr_data)
  );

  // floor square root of the radicand: four times the chosen component
  rmq_sqrt u_sqrt (
    .clk, .rst_n,
    .up_valid (fr_valid), .up_ready (fr_ready), .up_data (fr_data),
    .dn_valid (sq_valid), .dn_ready (sq_ready), .dn_data (sq_data)
  );

  // divide the three numerators by the root
  rmq_div u_div (
    .clk, .rst_n,
    .up_valid (sq_valid), .up_ready (sq_ready), .up_data (sq_data),
    .dn_valid (dv_valid), .dn_ready (dv_ready), .dn_data (dv_data)
  );

  // round, saturate and place the components; holds the result until taken
  rmq_out u_out (
    .clk, .rst_n,
    .up_valid (dv_valid),     .up_ready (dv_ready),     .up_data (dv_data),
    .dn_valid (out_ch.valid), .dn_ready (out_ch.ready), .dn_data (res)
  );

  assign out_ch.q_scalar     = res.q_scalar;
  assign out_ch.q_x          = res.q_x;
  assign out_ch.q_y          = res.q_y;
  assign out_ch.q_z          = res.q_z;
  assign out_ch.not_rotation = res.not_rotation;

  // a flagged result carries an all-zero quaternion
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.not_rotation |->
      out_ch.q_scalar == '0 && out_ch.q_x == '0 && out_ch.q_y == '0 && out_ch.q_z == '0)
    else $error("flagged result with nonzero quaternion");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  // a full output register with a stalled consumer blocks the divider tail
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !dv_ready)
    else $error("output stage overwritten while stalled");

endmodule
